FILE: rtl/core/dcfs_pkg.sv
// Shared types, constants and the word packing function of the frame serializer.
package dcfs_pkg;

    localparam int unsigned WORD_W    = 14;
    localparam int unsigned TICK_W    = 6;
    localparam int unsigned ROW_W     = 6;
    localparam int unsigned PHASE_W   = 5;

    localparam logic [TICK_W-1:0] LAST_TICK       = 6'd31;
    localparam logic [TICK_W-1:0] LAST_CLOCK_TICK = 6'd25;
    localparam logic [TICK_W-1:0] HT_TICK_FIRST   = 6'd28;
    localparam logic [TICK_W-1:0] HT_TICK_SECOND  = 6'd30;
    localparam logic [TICK_W-1:0] LAST_VA_TICK    = 6'd2;
    localparam logic [TICK_W-1:0] WORD_TOP_BIT    = 6'd13;

    typedef enum logic
    {
        KIND_TICK = 1'b0,
        KIND_SEND = 1'b1
    } kind_t;

    typedef struct packed
    {
        kind_t              kind;
        logic [ROW_W-1:0]   row;
        logic               strobe_select;
        logic               mem_bit_a;
        logic [PHASE_W-1:0] phase_a;
        logic               mem_bit_b;
        logic [PHASE_W-1:0] phase_b;
    } req_item_t;

    typedef struct packed
    {
        logic va_line;
        logic data_a_line;
        logic data_b_line;
        logic clock_line;
        logic ht_line;
        logic frame_busy;
    } res_item_t;

    typedef struct packed
    {
        logic      valid;
        res_item_t item;
    } res_push_t;

    // Bit 0 is even parity over the upper bits, bit 6 stays zero.
    function automatic logic [WORD_W-1:0] pack_word(
        input logic [ROW_W-1:0]   row,
        input logic               mem,
        input logic [PHASE_W-1:0] phase
    );
        logic [WORD_W-1:0] w;
        begin
            w = {row, mem, 1'b0, phase, 1'b0};
            w[0] = ^w[WORD_W-1:1];
            return w;
        end
    endfunction

endpackage

FILE: rtl/core/dcfs_stream_if.sv
// Valid/ready request channel interface with a typed payload.
interface dcfs_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/dcfs_frame_gen.sv
// Frame state and per-tick line level decode.
module dcfs_frame_gen (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  dcfs_pkg::req_item_t req,
    output dcfs_pkg::res_push_t push
);
    import dcfs_pkg::*;

    logic                armed_reg, armed_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [WORD_W-1:0]   word_a_reg, word_a_next;
    logic [WORD_W-1:0]   word_b_reg, word_b_next;
    logic                strobe_sel_reg, strobe_sel_next;

    logic                in_frame;
    logic [3:0]          idx_a;
    logic [3:0]          idx_b;
    res_item_t           levels;

    always_comb
    begin
        in_frame = armed_reg && (tick_reg <= LAST_TICK);
        idx_a    = 4'(WORD_TOP_BIT[3:0] - tick_reg[3:0]);
        idx_b    = 4'(WORD_TOP_BIT[3:0] - tick_reg[3:0]);
        levels   = '0;
        if (in_frame)
        begin
            levels.va_line     = (tick_reg <= LAST_VA_TICK);
            // Word A is held low at tick 0, as word A has no bit 14; tick t sends bit 14-t.
            levels.data_a_line = (tick_reg >= 6'd1) && (tick_reg <= WORD_TOP_BIT + 6'd1)
                                 && word_a_reg[4'(idx_a + 4'd1)];
            levels.data_b_line = (tick_reg <= WORD_TOP_BIT) && word_b_reg[idx_b];
            levels.clock_line  = !(tick_reg[0] && (tick_reg <= LAST_CLOCK_TICK));
            levels.ht_line     = (tick_reg == HT_TICK_FIRST)
                                 || ((tick_reg == HT_TICK_SECOND) && strobe_sel_reg);
            levels.frame_busy  = 1'b1;
        end
        push.valid = accept && (req.kind == KIND_TICK);
        push.item  = levels;
    end

    always_comb
    begin
        armed_next      = armed_reg;
        tick_next       = tick_reg;
        word_a_next     = word_a_reg;
        word_b_next     = word_b_reg;
        strobe_sel_next = strobe_sel_reg;
        if (accept)
        begin
            if (req.kind == KIND_SEND)
            begin
                word_a_next     = pack_word(req.row, req.mem_bit_a, req.phase_a);
                word_b_next     = pack_word(req.row, req.mem_bit_b, req.phase_b);
                strobe_sel_next = req.strobe_select;
                armed_next      = 1'b1;
            end
            else if (in_frame)
            begin
                tick_next = tick_reg + 6'd1;
            end
            else
            begin
                tick_next  = '0;
                armed_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg      <= 1'b0;
            tick_reg       <= '0;
            word_a_reg     <= '0;
            word_b_reg     <= '0;
            strobe_sel_reg <= 1'b0;
        end
        else
        begin
            armed_reg      <= armed_next;
            tick_reg       <= tick_next;
            word_a_reg     <= word_a_next;
            word_b_reg     <= word_b_next;
            strobe_sel_reg <= strobe_sel_next;
        end
    end

endmodule

FILE: rtl/core/dcfs_out_buf.sv
// Two-entry result buffer that decouples the request side from output stalls.
module dcfs_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  dcfs_pkg::res_push_t push,
    output logic                can_push,
    output logic                res_valid,
    input  logic                res_ready,
    output dcfs_pkg::res_item_t res_item
);
    import dcfs_pkg::*;

    res_item_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    always_comb
    begin
        can_push    = (count_reg != 2'd2);
        res_valid   = (count_reg != 2'd0);
        res_item    = entry_reg[rd_ptr_reg];
        pop         = res_valid && res_ready;
        wr_ptr_next = wr_ptr_reg ^ push.valid;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push.valid} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_ptr_reg] <= push.item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/core/dual_channel_frame_serializer.sv
// Top level of the dual-channel frame serializer.
// The req_ch channel takes two kinds of request: a send request, which packs
// the two data words, stores the strobe select and arms the frame, and a
// tick, which steps the frame by one tick. A send request gives no result.
// Each tick gives one result on res_ch: the levels of the VA marker, both
// data lines, the bit clock, the HT strobe and a frame busy flag.
// A send during a frame replaces the words but keeps the tick count.
// After tick 31, or when no frame is armed, a tick gives all lines low and
// disarms the frame.
// One request is accepted per cycle while req_ch.ready is high. A tick result
// is registered in a two-entry result buffer and leaves it on res_ch.
// When the receiver stalls, the buffer fills and req_ch.ready drops only once
// both entries hold results; no result is lost or repeated.
// Reset disarms the frame, clears the tick count and the words, and empties
// the result buffer.
module dual_channel_frame_serializer (
    input logic        clk,
    input logic        rst_n,
    dcfs_stream_if.sink   req_ch,
    dcfs_stream_if.source res_ch
);
    import dcfs_pkg::*;

    logic      accept;
    logic      can_push;
    res_push_t push;
    req_item_t req;
    res_item_t res_item;

    assign req          = req_ch.data;
    assign req_ch.ready = can_push;
    assign accept       = req_ch.valid && can_push;
    assign res_ch.data  = res_item;

    dcfs_frame_gen u_frame_gen (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req),
        .push   (push)
    );

    dcfs_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .can_push  (can_push),
        .res_valid (res_ch.valid),
        .res_ready (res_ch.ready),
        .res_item  (res_item)
    );

endmodule
